@@ sv/atrp_pkg.sv @@
`default_nettype none

package atrp_pkg;

	localparam int ANG_W = 26;
	localparam int TABLE_LEN = 24;
	localparam int FRAC_SH = 16;
	localparam int OUT_SH = 9;
	localparam logic signed [ANG_W-1:0] HALF_TURN_Q16 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] ROUND_HALF = 26'sd256;
	localparam logic signed [ANG_W-1:0] ROLL_LIMIT = 26'sd23040;
	localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 26'sd11520;

	// atan(2^-i) in 2^-16 degree
	function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0: r = 26'sd2949120;
			1: r = 26'sd1740967;
			2: r = 26'sd919879;
			3: r = 26'sd466945;
			4: r = 26'sd234379;
			5: r = 26'sd117304;
			6: r = 26'sd58666;
			7: r = 26'sd29335;
			8: r = 26'sd14668;
			9: r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/atrp_sqrt_cell.sv @@
`default_nettype none

module atrp_sqrt_cell #(
	parameter int SQ_W = 28,
	parameter int R_W = 30,
	parameter int P = 0,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [SQ_W-1:0]   sq_i,
	input  logic [R_W+2:0]    rem_i,
	input  logic [R_W-1:0]    root_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic [SQ_W-1:0]   sq_o,
	output logic [R_W+2:0]    rem_o,
	output logic [R_W-1:0]    root_o,
	output logic [SIDE_W-1:0] side_o
);
	import atrp_pkg::*;

	localparam int N_W = SQ_W + 2 * FRAC_SH;

	logic [N_W-1:0]    n_full;
	logic [R_W+2:0]    rem_sh;
	logic [R_W+2:0]    trial;
	logic              take;
	logic [SQ_W-1:0]   sq_q;
	logic [R_W+2:0]    rem_q;
	logic [R_W-1:0]    root_q;
	logic [SIDE_W-1:0] side_q;

	assign n_full = {sq_i, {(2 * FRAC_SH){1'b0}}};
	assign rem_sh = {rem_i[R_W:0], n_full[2*P+1 -: 2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign take = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= sq_i;
			rem_q <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_i[R_W-2:0], take};
		end
	end

	assign sq_o = sq_q;
	assign rem_o = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

`default_nettype wire

@@ sv/atrp_cordic_cell.sv @@
`default_nettype none

module atrp_cordic_cell #(
	parameter int W = 33,
	parameter int STEP = 0,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic signed [W-1:0]             x_i,
	input  logic signed [W-1:0]             y_i,
	input  logic signed [atrp_pkg::ANG_W-1:0] z_i,
	input  logic [SIDE_W-1:0]               side_i,
	output logic signed [W-1:0]             x_o,
	output logic signed [W-1:0]             y_o,
	output logic signed [atrp_pkg::ANG_W-1:0] z_o,
	output logic [SIDE_W-1:0]               side_o
);
	import atrp_pkg::*;

	logic signed [W-1:0]     dx;
	logic signed [W-1:0]     dy;
	logic signed [ANG_W-1:0] ent;
	logic signed [W-1:0]     x_q;
	logic signed [W-1:0]     y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [SIDE_W-1:0]       side_q;

	assign dx = y_i >>> STEP;
	assign dy = x_i >>> STEP;
	assign ent = atan_q16(STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[W-1]) begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + ent;
			end else begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - ent;
			end
		end
	end

	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;
	assign side_o = side_q;

endmodule

`default_nettype wire

@@ sv/accel_tilt_roll_pitch_core.sv @@
// Roll = atan2(y, z) and pitch = atan2(x, sqrt(y*y + z*z)) from one signed three-axis
// accelerometer sample, in 1/128 degree rounded to nearest; atan2(0,0) gives 0. One word is
// taken every cycle while the output side accepts; a stall on the output holds the whole
// pipeline. Its stages are input, squaring and sum stages, one square-root cell per root bit,
// one CORDIC cell per rotation step for each angle, and the rounding and clamping output
// register.
`default_nettype none

module accel_tilt_roll_pitch_core #(
	parameter int SAMPLE_BITS = 14,
	parameter int ANGLE_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// accel_x, accel_y, accel_z, zero pad
	input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// roll_angle, pitch_angle, zero pad
	output logic [31:0] m_axis_tdata
);
	import atrp_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int SQ_W = 2 * SB;
	localparam int R_W = SB + FRAC_SH;
	localparam int W = SB + FRAC_SH + 3;
	localparam int STEPS = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;
	localparam int SIDE_W = 1 + 3 * SB;

	logic en;

	logic                 v_s1, v_s2, v_s3;
	logic signed [SB-1:0] ax_s1, ay_s1, az_s1;
	logic signed [SB-1:0] ax_s2, ay_s2, az_s2;
	logic signed [SB-1:0] ax_s3, ay_s3, az_s3;
	logic signed [SQ_W-1:0] yy_s2, zz_s2;
	logic [SQ_W-1:0]      sq_s3;

	logic [SQ_W-1:0]   sq_c   [0:R_W];
	logic [R_W+2:0]    rem_c  [0:R_W];
	logic [R_W-1:0]    root_c [0:R_W];
	logic [SIDE_W-1:0] side_c [0:R_W];

	logic                 sv;
	logic signed [SB-1:0] sx, sy, sz;
	logic signed [W-1:0]  ra, rb, pa, pb;
	logic                 roll_zero, pitch_zero;

	logic signed [W-1:0]     rx_c [0:STEPS];
	logic signed [W-1:0]     ry_c [0:STEPS];
	logic signed [ANG_W-1:0] rz_c [0:STEPS];
	logic [1:0]              rs_c [0:STEPS];
	logic signed [W-1:0]     px_c [0:STEPS];
	logic signed [W-1:0]     py_c [0:STEPS];
	logic signed [ANG_W-1:0] pz_c [0:STEPS];
	logic                    ps_c [0:STEPS];

	logic signed [ANG_W-1:0] r_sh, p_sh, r_cl, p_cl;
	logic                    out_v_q;
	logic [15:0]             roll_q;
	logic [14:0]             pitch_q;

	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= s_axis_tdata[SB-1:0];
			ay_s1 <= s_axis_tdata[2*SB-1:SB];
			az_s1 <= s_axis_tdata[3*SB-1:2*SB];
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			az_s2 <= az_s1;
			yy_s2 <= ay_s1 * ay_s1;
			zz_s2 <= az_s1 * az_s1;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;
			sq_s3 <= yy_s2 + zz_s2;
		end
	end

	assign sq_c[0] = sq_s3;
	assign rem_c[0] = '0;
	assign root_c[0] = '0;
	assign side_c[0] = {v_s3, az_s3, ay_s3, ax_s3};

	for (genvar k = 0; k < R_W; k++) begin : g_sqrt
		atrp_sqrt_cell #(
			.SQ_W(SQ_W),
			.R_W(R_W),
			.P(R_W - 1 - k),
			.SIDE_W(SIDE_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.sq_i(sq_c[k]),
			.rem_i(rem_c[k]),
			.root_i(root_c[k]),
			.side_i(side_c[k]),
			.sq_o(sq_c[k+1]),
			.rem_o(rem_c[k+1]),
			.root_o(root_c[k+1]),
			.side_o(side_c[k+1])
		);
	end

	assign sx = side_c[R_W][SB-1:0];
	assign sy = side_c[R_W][2*SB-1:SB];
	assign sz = side_c[R_W][3*SB-1:2*SB];
	assign sv = side_c[R_W][SIDE_W-1];

	assign ra = W'(sy) <<< FRAC_SH;
	assign rb = W'(sz) <<< FRAC_SH;
	assign pa = W'(sx) <<< FRAC_SH;
	assign pb = $signed(W'(root_c[R_W]));
	assign roll_zero = (sy == '0) && (sz == '0);
	assign pitch_zero = (sx == '0) && (root_c[R_W] == '0);

	assign rx_c[0] = (rb < 0) ? -rb : rb;
	assign ry_c[0] = (rb < 0) ? -ra : ra;
	assign rz_c[0] = (rb >= 0) ? '0 : ((ra >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16);
	assign rs_c[0] = {sv, roll_zero};
	assign px_c[0] = pb;
	assign py_c[0] = pa;
	assign pz_c[0] = '0;
	assign ps_c[0] = pitch_zero;

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		atrp_cordic_cell #(
			.W(W),
			.STEP(i),
			.SIDE_W(2)
		) u_roll (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.x_i(rx_c[i]),
			.y_i(ry_c[i]),
			.z_i(rz_c[i]),
			.side_i(rs_c[i]),
			.x_o(rx_c[i+1]),
			.y_o(ry_c[i+1]),
			.z_o(rz_c[i+1]),
			.side_o(rs_c[i+1])
		);
		atrp_cordic_cell #(
			.W(W),
			.STEP(i),
			.SIDE_W(1)
		) u_pitch (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.x_i(px_c[i]),
			.y_i(py_c[i]),
			.z_i(pz_c[i]),
			.side_i(ps_c[i]),
			.x_o(px_c[i+1]),
			.y_o(py_c[i+1]),
			.z_o(pz_c[i+1]),
			.side_o(ps_c[i+1])
		);
	end

	assign r_sh = (rz_c[STEPS] + ROUND_HALF) >>> OUT_SH;
	assign p_sh = (pz_c[STEPS] + ROUND_HALF) >>> OUT_SH;

	always_comb begin
		if (rs_c[STEPS][0]) begin
			r_cl = '0;
		end else if (r_sh > ROLL_LIMIT) begin
			r_cl = ROLL_LIMIT;
		end else if (r_sh < -ROLL_LIMIT) begin
			r_cl = -ROLL_LIMIT;
		end else begin
			r_cl = r_sh;
		end
		if (ps_c[STEPS]) begin
			p_cl = '0;
		end else if (p_sh > PITCH_LIMIT) begin
			p_cl = PITCH_LIMIT;
		end else if (p_sh < -PITCH_LIMIT) begin
			p_cl = -PITCH_LIMIT;
		end else begin
			p_cl = p_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= rs_c[STEPS][1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q <= r_cl[15:0];
			pitch_q <= p_cl[14:0];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {1'b0, pitch_q, roll_q};

`ifndef SYNTHESIS
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040 &&
			$signed(m_axis_tdata[15:0]) >= -16'sd23040))
		else $error("roll out of range");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd11520 &&
			$signed(m_axis_tdata[30:16]) >= -15'sd11520))
		else $error("pitch out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> $stable(rs_c[STEPS]))
		else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

@@ bench/accel_tilt_roll_pitch_core_tb.sv @@
`timescale 1ns / 100ps

module accel_tilt_roll_pitch_core_tb;
	import atrp_pkg::*;

	localparam int SB = 14;
	localparam int IN_W = ((3*SB+7)/8)*8;
	localparam int LATENCY = 50;
	localparam longint MAX_CYCLES = 2000000;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
	} angles_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;

	angles_t expected_angles[$];
	int errors = 0;
	longint cycles = 0;
	bit send_idle = 1;
	bit recv_idle = 1;
	int recv_hold = 0;

	longint atan_step[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	accel_tilt_roll_pitch_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint a, longint b, longint lim);
		longint x, y, z, dx, dy, r;
		if (a == 0 && b == 0) return 0;
		if (b < 0) begin
			x = -b;
			y = -a;
			z = (a >= 0) ? 180*65536 : -180*65536;
		end else begin
			x = b;
			y = a;
			z = 0;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += atan_step[i];
			end else begin
				x -= dx;
				y += dy;
				z -= atan_step[i];
			end
		end
		r = (z + 256) >>> 9;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic angles_t tilt_of(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
			logic signed [SB-1:0] z);
		angles_t t;
		longint ax, ay, az, mag;
		ax = x;
		ay = y;
		az = z;
		mag = root_floor(longint'(ay*ay + az*az) << 32);
		t.roll = 16'(vector_angle(ay*65536, az*65536, 23040));
		t.pitch = 15'(vector_angle(ax*65536, mag, 11520));
		return t;
	endfunction

	task automatic send_sample(logic signed [SB-1:0] x, logic signed [SB-1:0] y,
			logic signed [SB-1:0] z);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W-3*SB){1'b0}}, z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		expected_angles.push_back(tilt_of(x, y, z));
	endtask

	task automatic send_random;
		logic signed [SB-1:0] x, y, z;
		x = SB'($urandom);
		y = SB'($urandom);
		z = SB'($urandom);
		case ($urandom_range(0, 7))
			0: x = SB'(int'($urandom_range(0, 7)) - 4);
			1: y = SB'(int'($urandom_range(0, 7)) - 4);
			2: z = SB'(int'($urandom_range(0, 7)) - 4);
			3: begin
				y = SB'(int'($urandom_range(0, 3)) - 2);
				z = SB'(int'($urandom_range(0, 3)) - 2);
			end
			default: ;
		endcase
		send_sample(x, y, z);
	endtask

	task automatic wait_drained;
		while (expected_angles.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed;
		send_sample(0, 0, 0);
		send_sample(100, 0, 0);
		send_sample(-100, 0, 0);
		send_sample(0, 0, -8192);
		send_sample(0, -1, -8192);
		send_sample(0, 1, -8192);
		send_sample(0, 8191, -1);
		send_sample(0, -8192, -1);
		send_sample(8191, 0, 0);
		send_sample(-8192, 0, 0);
		send_sample(8191, 8191, 8191);
		send_sample(-8192, -8192, -8192);
		send_sample(-8192, 8191, -8192);
		send_sample(8191, -8192, 8191);
		send_sample(1, 1, 1);
		send_sample(-1, -1, -1);
		send_sample(0, 8191, 0);
		send_sample(0, -8192, 0);
		send_sample(0, 0, 8191);
		send_sample(5461, 2730, -5461);
	endtask

	task automatic test_random_stream(int n);
		for (int i = 0; i < n; i++) send_random();
	endtask

	task automatic test_pause_until_empty;
		send_random();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		test_random_stream(40);
	endtask

	task automatic test_back_to_back;
		send_idle = 0;
		recv_idle = 0;
		test_random_stream(150);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_hold <= 0;
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_idle && $urandom_range(0, 5) == 0) begin
			recv_hold <= $urandom_range(0, 17);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		angles_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.roll = m_axis_tdata[15:0];
			got.pitch = m_axis_tdata[30:16];
			if (expected_angles.size() == 0) begin
				$error("unexpected word: roll_angle %0d pitch_angle %0d", got.roll, got.pitch);
				errors++;
			end else begin
				want = expected_angles.pop_front();
				if (got.roll !== want.roll) begin
					$error("roll_angle expected %0d actual %0d", want.roll, got.roll);
					errors++;
				end
				if (got.pitch !== want.pitch) begin
					$error("pitch_angle expected %0d actual %0d", want.pitch, got.pitch);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream(300);
		test_pause_until_empty();
		test_random_stream(220);
		test_back_to_back();
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_angles.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/atrp_pkg.sv
sv/atrp_sqrt_cell.sv
sv/atrp_cordic_cell.sv
sv/accel_tilt_roll_pitch_core.sv
bench/accel_tilt_roll_pitch_core_tb.sv
